/* sv/lisl_pkg.sv */
`default_nettype none

package lisl_pkg;

  // Width of the reported length field
  localparam int unsigned OUT_LEN_W = 7;

  // Signals rippling from one cell to the next
  typedef struct packed {
    logic hit;    // some cell at or below this one holds a tail >= key
    logic valid;  // this cell holds a live tail
  } lisl_link_t;

endpackage

`default_nettype wire

/* sv/lisl_cell.sv */
`default_nettype none

module lisl_cell #(
  parameter int unsigned VALUE_WIDTH = 16,
  parameter int unsigned LEN_W       = 7,
  parameter int unsigned IDX         = 0
) (
  input  wire                     clk,
  input  wire                     upd,
  input  wire  [VALUE_WIDTH-1:0]  key,
  input  wire  [LEN_W-1:0]        len,
  input  lisl_pkg::lisl_link_t    link_i,
  output lisl_pkg::lisl_link_t    link_o
);

  import lisl_pkg::*;

  logic [VALUE_WIDTH-1:0] tail_r;
  logic                   live;
  logic                   ge;
  logic                   wr;

  // Cell holds a tail only while its index is below the table length
  assign live = LEN_W'(IDX) < len;
  assign ge   = live && ($signed(tail_r) >= $signed(key));

  // Replace the first tail >= key, or append at the first empty slot
  // when no live tail is >= key
  assign wr = (live && ge && !link_i.hit) ||
              (!live && link_i.valid && !link_i.hit);

  assign link_o.hit   = link_i.hit || ge;
  assign link_o.valid = live;

  always_ff @(posedge clk) begin
    if (upd && wr) begin
      tail_r <= key;
    end
  end

endmodule

`default_nettype wire

/* sv/longest_increasing_subsequence_length_core.sv */
`default_nettype none

// Channel  Direction  Handshake               Fields
// in       input      in_valid / in_ready     in_value, in_last
// out      output     out_valid / out_ready   out_lis_length, out_overflow,
//                                             out_end_of_sequence
//
// One item per cycle: every cell compares the incoming value with its tail
// in parallel and the hit flag ripples down the row of MAX_TAILS cells.
// The result is registered and appears on out in the cycle after the item is accepted.
// A new item is taken whenever the output register is empty or being drained.
// Synchronous active-low reset clears the length, the overflow flag and out_valid;
// tails need no clearing since only cells below the length are looked at.

module longest_increasing_subsequence_length_core #(
  parameter int unsigned MAX_TAILS   = 64,
  parameter int unsigned VALUE_WIDTH = 16
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_valid,
  output logic                                 in_ready,
  input  wire  [VALUE_WIDTH-1:0]               in_value,
  input  wire                                  in_last,
  output logic                                 out_valid,
  input  wire                                  out_ready,
  output logic [lisl_pkg::OUT_LEN_W-1:0]       out_lis_length,
  output logic                                 out_overflow,
  output logic                                 out_end_of_sequence
);

  import lisl_pkg::*;

  localparam int unsigned LEN_W = $clog2(MAX_TAILS + 1);

  logic [LEN_W-1:0]          len_r;
  logic [LEN_W-1:0]          len_nxt;
  logic                      ovf_r;
  logic                      ovf_nxt;
  logic                      out_valid_r;
  logic [OUT_LEN_W-1:0]      out_len_r;
  logic                      out_ovf_r;
  logic                      out_eos_r;
  logic                      accept;
  logic                      full;
  logic [LEN_W+OUT_LEN_W-1:0] len_ext;
  lisl_link_t                link [MAX_TAILS+1];

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign full     = len_r == LEN_W'(MAX_TAILS);

  // Head of the row: nothing hit yet, and slot "below" cell 0 counts as live
  assign link[0].hit   = 1'b0;
  assign link[0].valid = 1'b1;

  // Row of tail cells
  for (genvar k = 0; k < MAX_TAILS; k++) begin : g_cell
    lisl_cell #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .LEN_W       (LEN_W),
      .IDX         (k)
    ) u_cell (
      .clk    (clk),
      .upd    (accept),
      .key    (in_value),
      .len    (len_r),
      .link_i (link[k]),
      .link_o (link[k+1])
    );
  end

  // Length grows when no tail is >= value; full table sets overflow instead
  always_comb begin
    len_nxt = len_r;
    ovf_nxt = ovf_r;
    if (!link[MAX_TAILS].hit) begin
      if (full) begin
        ovf_nxt = 1'b1;
      end else begin
        len_nxt = len_r + LEN_W'(1);
      end
    end
  end

  assign len_ext = {{OUT_LEN_W{1'b0}}, len_nxt};

  // Sequence state; cleared after the last item's result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
      ovf_r <= 1'b0;
    end else if (accept) begin
      if (in_last) begin
        len_r <= '0;
        ovf_r <= 1'b0;
      end else begin
        len_r <= len_nxt;
        ovf_r <= ovf_nxt;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_len_r <= len_ext[OUT_LEN_W-1:0];
      out_ovf_r <= ovf_nxt;
      out_eos_r <= in_last;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_lis_length      = out_len_r;
  assign out_overflow        = out_ovf_r;
  assign out_end_of_sequence = out_eos_r;

  // Checks
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LEN_W'(MAX_TAILS))
    else $error("length beyond table size");

  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> full)
    else $error("overflow flag set with table not full");

  a_accept_out: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted item produced no result");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_last |=> len_r == '0 && !ovf_r)
    else $error("sequence state not cleared after last item");

endmodule

`default_nettype wire

/* tb/testbench.sv */
`default_nettype none

module testbench;
  import lisl_pkg::*;

  localparam int MAX_TAILS   = 64;
  localparam int VALUE_WIDTH = 16;
  localparam int RAND_ITEMS  = 900;
  localparam int STALL_LIMIT = 2000;
  localparam int N_ROWS      = 21;

  // One reported length
  typedef struct packed {
    logic [OUT_LEN_W-1:0] length;
    logic                 overflow;
    logic                 eos;
  } lis_result_t;

  // Directed stimulus row; typed rows carry their own expected length
  typedef struct {
    int value;
    bit last;
    bit typed;
    int length;
    bit overflow;
  } seed_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [VALUE_WIDTH-1:0] in_value = '0;
  logic in_last = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [OUT_LEN_W-1:0] out_lis_length;
  logic out_overflow;
  logic out_end_of_sequence;

  // Expectation attached to the item currently offered
  bit          row_typed = 1'b0;
  lis_result_t row_exp = '0;
  bit          calm = 1'b0;

  // Shadow of the tails table
  logic signed [VALUE_WIDTH-1:0] tails_q [MAX_TAILS];
  int tails_len = 0;
  bit tails_ovf = 1'b0;

  lis_result_t lengths_due [$];
  int mismatches = 0;
  int items_in = 0;
  int results_out = 0;
  int sequences = 0;
  int ovf_results = 0;
  int longest = 0;
  int stall_cycles = 0;
  int sent = 0;

  seed_row_t seed_rows [N_ROWS] = '{
    '{0,      0, 1, 1, 0},  // first element after reset
    '{32767,  0, 1, 2, 0},  // largest value extends
    '{-32768, 0, 1, 2, 0},  // smallest value replaces the first tail
    '{-32768, 0, 1, 2, 0},  // equal to first tail: replaced, no growth
    '{32767,  0, 1, 2, 0},  // equal to last tail: replaced, no growth
    '{100,    0, 0, 0, 0},
    '{200,    1, 1, 3, 0},  // extends, closes the sequence
    '{5,      1, 1, 1, 0},  // one-element sequence
    '{-1,     0, 1, 1, 0},
    '{-2,     0, 1, 1, 0},
    '{-32768, 0, 1, 1, 0},
    '{32767,  0, 1, 2, 0},
    '{3,      0, 0, 0, 0},
    '{1,      0, 0, 0, 0},
    '{4,      0, 0, 0, 0},
    '{1,      0, 0, 0, 0},
    '{5,      0, 0, 0, 0},
    '{9,      0, 0, 0, 0},
    '{2,      0, 0, 0, 0},
    '{6,      0, 0, 0, 0},
    '{-32768, 1, 0, 0, 0}
  };

  longest_increasing_subsequence_length_core #(
    .MAX_TAILS  (MAX_TAILS),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_value           (in_value),
    .in_last            (in_last),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_lis_length     (out_lis_length),
    .out_overflow       (out_overflow),
    .out_end_of_sequence(out_end_of_sequence)
  );

  always #5 clk = ~clk;

  // Patience-sort step: extend, replace first tail >= value, or saturate
  function automatic lis_result_t advance_tails(logic signed [VALUE_WIDTH-1:0] v, logic l);
    lis_result_t r;
    int pos;
    if (tails_len == 0 || v > tails_q[tails_len-1]) begin
      if (tails_len < MAX_TAILS) begin
        tails_q[tails_len] = v;
        tails_len++;
      end else begin
        tails_ovf = 1'b1;
      end
    end else begin
      pos = 0;
      while (pos < tails_len - 1 && tails_q[pos] < v) pos++;
      tails_q[pos] = v;
    end
    r.length = tails_len[OUT_LEN_W-1:0];
    r.overflow = tails_ovf;
    r.eos = l;
    if (l) begin
      tails_len = 0;
      tails_ovf = 1'b0;
    end
    return r;
  endfunction

  function automatic int clamp_value(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // Input acceptance feeds the expectation queue before outputs are checked
  always @(posedge clk) begin
    lis_result_t pred;
    lis_result_t want;
    lis_result_t got;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        pred = advance_tails(in_value, in_last);
        lengths_due.push_back(row_typed ? row_exp : pred);
        items_in++;
      end
      if (out_valid && out_ready) begin
        got = '{out_lis_length, out_overflow, out_end_of_sequence};
        results_out++;
        if (got.overflow) ovf_results++;
        if (got.eos) sequences++;
        if (int'(got.length) > longest) longest = int'(got.length);
        if (lengths_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: unexpected result len=%0d ovf=%0b eos=%0b",
                     got.length, got.overflow, got.eos);
        end else begin
          want = lengths_due.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"ERROR: result %0d: expected len=%0d ovf=%0b eos=%0b,",
                        " got len=%0d ovf=%0b eos=%0b"},
                       results_out, want.length, want.overflow, want.eos,
                       got.length, got.overflow, got.eos);
          end
        end
      end
    end
  end

  // Receiver backpressure
  always @(posedge clk) begin
    out_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 9);
  end

  // Watchdog on handshake progress
  always @(posedge clk) begin
    if (rst_n && !((in_valid && in_ready) || (out_valid && out_ready)))
      stall_cycles <= stall_cycles + 1;
    else
      stall_cycles <= 0;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Timeout: no handshake for %0d cycles", STALL_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Offer one item, with random gaps ahead of it unless calm is set, and hold until taken
  task automatic send_item(input int v, input bit l, input bit typed, input lis_result_t exp);
    while (!calm && $urandom_range(0, 99) < 9) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_value <= v[VALUE_WIDTH-1:0];
    in_last <= l;
    row_typed <= typed;
    row_exp <= exp;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sent++;
    calm <= (sent >= 300 && sent < 450);
  endtask

  task automatic drain_lengths();
    in_valid <= 1'b0;
    do @(posedge clk); while (lengths_due.size() != 0);
  endtask

  // Strictly rising run; noisy runs slip in values no higher than the running value
  task automatic send_climb(input int n, input bit noisy);
    int v;
    int i;
    v = $urandom_range(0, 2000) - 32768;
    for (i = 0; i < n; i++) begin
      if (noisy && $urandom_range(0, 11) == 0)
        send_item(clamp_value(v - $urandom_range(0, 300)), 1'b0, 1'b0, '0);
      v = clamp_value(v + $urandom_range(1, 900));
      send_item(v, i == n - 1, 1'b0, '0);
    end
  endtask

  initial begin
    int i;
    int n;
    int kind;
    int v;
    bit drained_mid;
    drained_mid = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows
    for (i = 0; i < N_ROWS; i++) begin
      send_item(seed_rows[i].value, seed_rows[i].last, seed_rows[i].typed,
                '{seed_rows[i].length[OUT_LEN_W-1:0], seed_rows[i].overflow,
                  seed_rows[i].last});
    end
    drain_lengths();

    // Fill the table exactly, then run past it into saturation
    send_climb(MAX_TAILS, 1'b0);
    send_climb(MAX_TAILS + 2, 1'b0);

    while (sent < RAND_ITEMS + N_ROWS) begin
      kind = $urandom_range(0, 9);
      if (kind < 3) begin
        send_climb($urandom_range(55, 70), 1'b1);
      end else if (kind < 7) begin
        // drifting walk, mostly upward
        n = $urandom_range(1, 40);
        v = $urandom_range(0, 65535) - 32768;
        for (i = 0; i < n; i++) begin
          v = clamp_value(v + $urandom_range(0, 400) - 150);
          send_item(v, i == n - 1, 1'b0, '0);
        end
      end else begin
        // full-range noise
        n = $urandom_range(1, 20);
        for (i = 0; i < n; i++)
          send_item($urandom_range(0, 65535) - 32768, i == n - 1, 1'b0, '0);
      end
      if (!drained_mid && sent >= 500) begin
        drain_lengths();
        drained_mid = 1'b1;
      end
    end

    drain_lengths();
    repeat (5) @(posedge clk);

    $display("Run: %0d items in, %0d results out over %0d closed sequences",
             items_in, results_out, sequences);
    $display("Longest length seen %0d, %0d results with overflow set, %0d mismatches",
             longest, ovf_results, mismatches);
    if (mismatches == 0 && lengths_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
